// ----- src/gzhf_pkg.sv -----
// Shared types and constants for the gzip header/footer parser.
// Holds parse phases, status codes, the result record and the section-order helper.
// No dependencies.
package gzhf_pkg;

    localparam logic [7:0] GZ_MAGIC_A   = 8'h1f;
    localparam logic [7:0] GZ_MAGIC_B   = 8'h8b;
    localparam logic [7:0] GZ_DEFLATE   = 8'h08;
    localparam logic [7:0] GZ_RESERVED  = 8'he0;
    localparam logic [7:0] GZ_F_CONT    = 8'h02;
    localparam logic [7:0] GZ_F_EXTRA   = 8'h04;
    localparam logic [7:0] GZ_F_NAME    = 8'h08;
    localparam logic [7:0] GZ_F_COMMENT = 8'h10;
    localparam int         FIXED_HDR_LEN = 10;
    localparam logic [3:0] FIXED_LAST_IDX = 4'(FIXED_HDR_LEN - 1);

    // Result beat: 3 + 8 + 4 * 32 = 139 bits, padded to 144
    localparam int RES_BITS   = 139;
    localparam int TDATA_BITS = ((RES_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        PH_FIXED,
        PH_CONT,
        PH_XLEN,
        PH_EXTRA,
        PH_NAME,
        PH_COMMENT,
        PH_BODY,
        PH_DROP
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD_MAGIC,
        ST_NOT_DEFLATE,
        ST_RESERVED,
        ST_PREMATURE
    } status_t;

    typedef struct packed {
        logic [31:0] original_size;
        logic [31:0] footer_crc;
        logic [31:0] data_offset;
        logic [31:0] mod_time;
        logic [7:0]  flag_bits;
        status_t     status;
    } result_t;

    // Optional section that follows 'after', given the header flags
    function automatic phase_t next_section(phase_t after, logic [7:0] flags);
        phase_t r;
        if (after < PH_CONT && (flags & GZ_F_CONT) != 8'd0) begin
            r = PH_CONT;
        end else if (after < PH_XLEN && (flags & GZ_F_EXTRA) != 8'd0) begin
            r = PH_XLEN;
        end else if (after < PH_NAME && (flags & GZ_F_NAME) != 8'd0) begin
            r = PH_NAME;
        end else if (after < PH_COMMENT && (flags & GZ_F_COMMENT) != 8'd0) begin
            r = PH_COMMENT;
        end else begin
            r = PH_BODY;
        end
        return r;
    endfunction

endpackage

// ----- src/gzhf_parser.sv -----
// Byte-wise gzip header/footer parse state and result formation.
// One byte is consumed per step; the result is combinational from state and byte.
// Depends on gzhf_pkg.
module gzhf_parser
    import gzhf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       end_of_file,
    output logic       res_valid,
    output result_t    res
);

    phase_t      phase_reg, phase_upd, phase_next;
    logic [3:0]  idx_reg, idx_upd, idx_next;
    logic [7:0]  flags_reg, flags_upd, flags_next;
    logic [31:0] mtime_reg, mtime_upd, mtime_next;
    logic [15:0] xrem_reg, xrem_upd, xrem_next;
    logic [31:0] hcount_reg, hcount_upd, hcount_next;
    logic [63:0] tail_reg, tail_upd, tail_next;
    status_t     perr_reg, perr_upd, perr_next;
    logic        err_fire;
    status_t     err_code;

    // Next state
    always_comb begin
        phase_upd  = phase_reg;
        idx_upd    = idx_reg;
        flags_upd  = flags_reg;
        mtime_upd  = mtime_reg;
        xrem_upd   = xrem_reg;
        perr_upd   = perr_reg;
        err_fire   = 1'b0;
        err_code   = ST_OK;
        tail_upd   = {data_byte, tail_reg[63:8]};
        hcount_upd = hcount_reg;
        if (phase_reg != PH_BODY && phase_reg != PH_DROP && hcount_reg != '1) begin
            hcount_upd = hcount_reg + 32'd1;
        end

        unique case (phase_reg)
            PH_FIXED: begin
                if (perr_reg == ST_OK) begin
                    if ((idx_reg == 4'd0 && data_byte != GZ_MAGIC_A) ||
                        (idx_reg == 4'd1 && data_byte != GZ_MAGIC_B)) begin
                        perr_upd = ST_BAD_MAGIC;
                    end else if (idx_reg == 4'd2 && data_byte != GZ_DEFLATE) begin
                        perr_upd = ST_NOT_DEFLATE;
                    end
                end
                if (idx_reg == 4'd3) begin
                    flags_upd = data_byte;
                end
                if (idx_reg >= 4'd4 && idx_reg <= 4'd7) begin
                    mtime_upd = mtime_reg | ({24'd0, data_byte} << {idx_reg[1:0], 3'b000});
                end
                if (idx_reg >= FIXED_LAST_IDX) begin
                    err_code = perr_upd;
                    if (err_code == ST_OK && (flags_reg & GZ_RESERVED) != 8'd0) begin
                        err_code = ST_RESERVED;
                    end
                    idx_upd = 4'd0;
                    if (err_code != ST_OK) begin
                        err_fire  = 1'b1;
                        phase_upd = PH_DROP;
                    end else begin
                        phase_upd = next_section(PH_FIXED, flags_reg);
                    end
                end else begin
                    idx_upd = idx_reg + 4'd1;
                end
            end
            PH_CONT: begin
                idx_upd = idx_reg + 4'd1;
                if (idx_upd >= 4'd2) begin
                    phase_upd = next_section(PH_CONT, flags_reg);
                    idx_upd   = 4'd0;
                end
            end
            PH_XLEN: begin
                if (idx_reg == 4'd0) begin
                    xrem_upd = {8'd0, data_byte};
                    idx_upd  = 4'd1;
                end else begin
                    xrem_upd = {data_byte, xrem_reg[7:0]};
                    idx_upd  = 4'd0;
                    if (xrem_upd == 16'd0) begin
                        phase_upd = next_section(PH_EXTRA, flags_reg);
                    end else begin
                        phase_upd = PH_EXTRA;
                    end
                end
            end
            PH_EXTRA: begin
                xrem_upd = xrem_reg - 16'd1;
                if (xrem_upd == 16'd0) begin
                    phase_upd = next_section(PH_EXTRA, flags_reg);
                    idx_upd   = 4'd0;
                end
            end
            PH_NAME: begin
                if (data_byte == 8'd0) begin
                    phase_upd = next_section(PH_NAME, flags_reg);
                    idx_upd   = 4'd0;
                end
            end
            PH_COMMENT: begin
                if (data_byte == 8'd0) begin
                    phase_upd = next_section(PH_COMMENT, flags_reg);
                    idx_upd   = 4'd0;
                end
            end
            PH_BODY, PH_DROP: begin
            end
            default: begin
            end
        endcase

        // The final byte restarts the parser for the next file
        if (end_of_file) begin
            phase_next  = PH_FIXED;
            idx_next    = 4'd0;
            flags_next  = 8'd0;
            mtime_next  = 32'd0;
            xrem_next   = 16'd0;
            hcount_next = 32'd0;
            tail_next   = 64'd0;
            perr_next   = ST_OK;
        end else begin
            phase_next  = phase_upd;
            idx_next    = idx_upd;
            flags_next  = flags_upd;
            mtime_next  = mtime_upd;
            xrem_next   = xrem_upd;
            hcount_next = hcount_upd;
            tail_next   = tail_upd;
            perr_next   = perr_upd;
        end
    end

    // Result
    always_comb begin
        res           = '0;
        res.flag_bits = flags_upd;
        res_valid     = 1'b0;
        if (err_fire) begin
            res_valid  = 1'b1;
            res.status = err_code;
        end else if (end_of_file && phase_upd != PH_DROP) begin
            res_valid = 1'b1;
            if (phase_upd == PH_BODY) begin
                res.status        = ST_OK;
                res.mod_time      = mtime_upd;
                res.data_offset   = hcount_upd;
                res.footer_crc    = tail_upd[31:0];
                res.original_size = tail_upd[63:32];
            end else begin
                res.status = ST_PREMATURE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_FIXED;
            idx_reg    <= 4'd0;
            flags_reg  <= 8'd0;
            mtime_reg  <= 32'd0;
            xrem_reg   <= 16'd0;
            hcount_reg <= 32'd0;
            tail_reg   <= 64'd0;
            perr_reg   <= ST_OK;
        end else if (step) begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            flags_reg  <= flags_next;
            mtime_reg  <= mtime_next;
            xrem_reg   <= xrem_next;
            hcount_reg <= hcount_next;
            tail_reg   <= tail_next;
            perr_reg   <= perr_next;
        end
    end

endmodule

// ----- src/gzhf_out_buf.sv -----
// Two-entry result buffer between the parser and the master-side stream.
// Lets the parser keep going while one result waits for the consumer.
// Depends on gzhf_pkg.
module gzhf_out_buf
    import gzhf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t m_res
);

    result_t    slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = count_reg != 2'd0;
    assign full     = count_reg == 2'd2;
    assign m_res    = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/gzip_header_footer_parser_top.sv -----
// Channel  Dir  Payload                                            Qualifier
// s_       in   tdata[7:0] data_byte, tlast end_of_file             s_tvalid & s_tready
// m_       out  tdata status/flags/mtime/offset/crc/size (144 bits) m_tvalid & m_tready
//
// One byte per cycle sustained while the buffer has room; a byte is held in the input
// register and parsed once the buffer is not full, and its result is written into the
// buffer at the end of that parse step, raising m_tvalid (only a byte that ends in an
// error, or the final byte of a file that has not failed already, gives one). aresetn is
// synchronous and clears control state at once but not the data registers. A two-entry
// result buffer absorbs output stalls; the input stalls only when both entries are held.
//
// Top level of the gzip header/footer parser: input register, parser, result buffer.
// Depends on gzhf_pkg, gzhf_parser and gzhf_out_buf.
module gzip_header_footer_parser_top
    import gzhf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,   // end_of_file
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_BITS-1:0] m_tdata    // [2:0] status, [10:3] flag_bits,
                                             // [42:11] mod_time, [74:43] data_offset,
                                             // [106:75] footer_crc, [138:107] original_size
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       step;
    logic       buf_full;
    logic       res_valid;
    result_t    res;
    result_t    m_res;

    assign step     = in_valid_reg && !buf_full;
    assign s_tready = !in_valid_reg || step;
    assign m_tdata  = {{(TDATA_BITS - RES_BITS){1'b0}}, m_res};

    always_comb begin
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    gzhf_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .data_byte   (in_byte_reg),
        .end_of_file (in_last_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    gzhf_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (step && res_valid),
        .push_data (res),
        .full      (buf_full),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (m_res)
    );

endmodule

// ----- src/gzhf_checker.sv -----
// Port-level checks for the gzip header/footer parser, bound to the top level.
// Depends on gzhf_pkg and gzip_header_footer_parser_top.
module gzhf_checker
    import gzhf_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [TDATA_BITS-1:0] m_tdata
);

    // Hold a stalled result beat
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // No result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Error results carry only status and flags
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != ST_OK |-> m_tdata[TDATA_BITS-1:11] == '0)
        else $error("error result has nonzero payload");

    // A good header is never shorter than the fixed part
    a_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == ST_OK |-> m_tdata[74:43] >= 32'(FIXED_HDR_LEN))
        else $error("data offset shorter than fixed header");

endmodule

bind gzip_header_footer_parser_top gzhf_checker u_gzhf_checker (.*);
